/* design/gslc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gslc_pkg;

    localparam int SAMPLE_W = 10;
    localparam int VOLT_W   = 9;
    localparam int CONC_W   = 9;
    localparam int BAR_W    = 6;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 32;
    localparam int PROD_W   = 16;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [VOLT_W-1:0]   volt_t;
    typedef logic [CONC_W-1:0]   conc_t;
    typedef logic [BAR_W-1:0]    bar_t;

    // Voltage weight of each converter bit, hundredths of a volt
    localparam volt_t BIT_WEIGHT [SAMPLE_W] = '{
        9'd1, 9'd1, 9'd2, 9'd4, 9'd8, 9'd16, 9'd31, 9'd62, 9'd125, 9'd250
    };

    localparam volt_t V_OFFSET    = 9'd10;
    localparam volt_t V_BAND_HIGH = 9'd333;
    localparam volt_t V_BAND_MID  = 9'd166;
    localparam conc_t CONC_MAX    = 9'd395;
    localparam logic [10:0] ALARM_LIMIT = 11'd387;
    localparam logic [6:0]  CONC_SCALE  = 7'd100;

    // Bar thresholds, from the hundreds and tens digits of the voltage
    localparam volt_t BAR_V6 = 9'd460;
    localparam volt_t BAR_V5 = 9'd400;
    localparam volt_t BAR_V4 = 9'd330;
    localparam volt_t BAR_V3 = 9'd260;
    localparam volt_t BAR_V2 = 9'd190;
    localparam volt_t BAR_V1 = 9'd100;

    localparam bar_t BAR_L6 = 6'h3f;
    localparam bar_t BAR_L5 = 6'h1f;
    localparam bar_t BAR_L4 = 6'h0f;
    localparam bar_t BAR_L3 = 6'h07;
    localparam bar_t BAR_L2 = 6'h03;
    localparam bar_t BAR_L1 = 6'h01;
    localparam bar_t BAR_L0 = 6'h00;

    typedef struct packed {
        bar_t  bar_leds;
        logic  gas_alarm;
        conc_t concentration;
        volt_t voltage;
    } result_t;

endpackage

`default_nettype wire

/* design/gas_sensor_level_classifier.sv */
// Path: an accepted s_ word passes the input register, then the result register,
// on its way to its m_ word.
// Throughput: one sample per cycle; both registers advance together when the
// result register is empty or its word is taken.
// Reset: synchronous, active low aresetn clears both valid flags only.
`timescale 1ns / 1ps
`default_nettype none

module gas_sensor_level_classifier (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    // [9:0] sample, [15:10] zero
    input  wire logic [gslc_pkg::S_DATA_W-1:0] s_tdata,
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    // [8:0] voltage, [17:9] concentration, [18] gas_alarm, [24:19] bar_leds,
    // [31:25] zero
    output      logic [gslc_pkg::M_DATA_W-1:0] m_tdata
);
    import gslc_pkg::*;

    logic    in_valid_reg;
    sample_t sample_reg;
    logic    out_valid_reg;
    result_t result_reg;
    result_t result_next;
    logic    advance;

    volt_t             volt;
    volt_t             diff;
    logic [PROD_W-1:0] prod;
    conc_t             conc_raw;
    conc_t             conc_adj;
    logic [10:0]       diff_x4;
    logic              alarm;
    bar_t              bar;

    // Move both stages whenever the result slot frees up
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            sample_reg <= s_tdata[SAMPLE_W-1:0];
        end
    end

    // Weighted bit sum
    always_comb begin
        volt = '0;
        for (int i = 0; i < SAMPLE_W; i++) begin
            if (sample_reg[i]) begin
                volt = volt + BIT_WEIGHT[i];
            end
        end
    end

    // Concentration: scale the offset voltage, trim per band, zero it over range
    assign diff     = (volt > V_OFFSET) ? volt - V_OFFSET : '0;
    assign prod     = PROD_W'(diff) * PROD_W'(CONC_SCALE);
    assign conc_raw = prod[PROD_W-1:7];

    always_comb begin
        priority if (volt <= V_OFFSET) begin
            conc_adj = '0;
        end else if (volt > V_BAND_HIGH) begin
            conc_adj = (conc_raw >= 9'd2) ? conc_raw - 9'd2 : '0;
        end else if (volt > V_BAND_MID) begin
            conc_adj = (conc_raw >= 9'd1) ? conc_raw - 9'd1 : '0;
        end else begin
            conc_adj = conc_raw;
        end
    end

    // Alarm on the scaled offset voltage
    assign diff_x4 = {diff, 2'b00};
    assign alarm   = (volt > V_OFFSET) && (diff_x4 >= ALARM_LIMIT);

    // Bar level from voltage thresholds
    always_comb begin
        priority if (volt >= BAR_V6) begin
            bar = BAR_L6;
        end else if (volt >= BAR_V5) begin
            bar = BAR_L5;
        end else if (volt >= BAR_V4) begin
            bar = BAR_L4;
        end else if (volt >= BAR_V3) begin
            bar = BAR_L3;
        end else if (volt >= BAR_V2) begin
            bar = BAR_L2;
        end else if (volt >= BAR_V1) begin
            bar = BAR_L1;
        end else begin
            bar = BAR_L0;
        end
    end

    always_comb begin
        result_next.voltage       = volt;
        result_next.concentration = (conc_adj > CONC_MAX) ? '0 : conc_adj;
        result_next.gas_alarm     = alarm;
        result_next.bar_leds      = alarm ? bar : BAR_L0;
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
        if (advance && in_valid_reg) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(result_reg);

    // Bar stays dark while the alarm is clear
    a_bar_needs_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !result_reg.gas_alarm |-> result_reg.bar_leds == BAR_L0)
        else $error("bar lit without alarm");

    // Nonzero concentration only above the offset voltage
    a_conc_needs_volt: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && result_reg.concentration != '0 |->
            result_reg.voltage > V_OFFSET)
        else $error("concentration without voltage");

    // A buffered sample reaches the result register when the pipe advances
    a_pipe_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && advance |=> out_valid_reg)
        else $error("sample lost between stages");

    // Alarm set implies at least the first bar step
    a_alarm_bar: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && result_reg.gas_alarm |-> result_reg.bar_leds != BAR_L0)
        else $error("alarm without bar");

endmodule

`default_nettype wire
